### design/sbe_pkg.sv
// Shared types, constants and the substitution table of the six-bit encoder.
// Used by sbe_pack, sbe_out_buf and six_bit_substitution_encoder_unit.
`default_nettype none
package sbe_pkg;

  localparam logic [7:0] KEY_XOR   = 8'h09;
  localparam logic [6:0] CHAR_BIAS = 7'h3C;

  // Number of leftover bits held between bytes: none, two or four.
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_TWO  = 2'd1,
    PH_FOUR = 2'd2
  } phase_t;

  // Characters produced by one byte, before biasing.
  typedef struct packed {
    logic [5:0] grp0;    // first character
    logic [5:0] grp1;    // second character, used only when two is set
    logic       two;     // the byte produced two characters
    logic       eom;     // the second character ends the message
  } pair_t;

  localparam logic [7:0] SUBST_TAB [256] = '{
    8'h8C, 8'h87, 8'h0D, 8'h85, 8'hD4, 8'h64, 8'h63, 8'hE5,
    8'hBA, 8'h7E, 8'hB8, 8'h68, 8'h9D, 8'h9F, 8'hF5, 8'hBC,
    8'hA0, 8'hE3, 8'h3A, 8'h22, 8'h19, 8'h21, 8'h39, 8'h78,
    8'hEE, 8'h27, 8'h36, 8'h15, 8'h74, 8'hC7, 8'h97, 8'hC9,
    8'hCE, 8'hE2, 8'h7B, 8'h4C, 8'h98, 8'hA1, 8'hC2, 8'h59,
    8'h41, 8'hC0, 8'h1E, 8'h2E, 8'h95, 8'hEB, 8'hDE, 8'h69,
    8'h1D, 8'h5B, 8'h53, 8'hDA, 8'hF4, 8'h0A, 8'h4F, 8'hBB,
    8'hB7, 8'h24, 8'h33, 8'h0F, 8'hC8, 8'h84, 8'h29, 8'h89,
    8'h3C, 8'h1C, 8'h08, 8'h49, 8'hC6, 8'hFE, 8'hCC, 8'h23,
    8'h3E, 8'hE1, 8'h4E, 8'h8B, 8'h13, 8'hE7, 8'h1A, 8'h5D,
    8'hCF, 8'hB1, 8'h47, 8'h8F, 8'hD8, 8'h72, 8'h4B, 8'h93,
    8'h6E, 8'h73, 8'h4D, 8'h94, 8'hDD, 8'h82, 8'h14, 8'hA7,
    8'h03, 8'hF9, 8'hF1, 8'hC5, 8'h8D, 8'h79, 8'h2A, 8'hC4,
    8'hDC, 8'h60, 8'h5F, 8'hD7, 8'h62, 8'hB5, 8'hE9, 8'hB3,
    8'hB6, 8'h12, 8'hA8, 8'h32, 8'hD9, 8'hC3, 8'h6A, 8'h75,
    8'h4A, 8'hA2, 8'h0C, 8'h26, 8'h91, 8'h5A, 8'hAD, 8'h6D,
    8'h44, 8'h10, 8'hB4, 8'h46, 8'h1B, 8'h66, 8'h81, 8'h20,
    8'hFD, 8'h7F, 8'h88, 8'h25, 8'h9C, 8'h71, 8'hD3, 8'hE6,
    8'h80, 8'hE4, 8'hFA, 8'h42, 8'h9B, 8'h37, 8'h01, 8'hFC,
    8'hDB, 8'h45, 8'h6B, 8'hFB, 8'h56, 8'hF0, 8'hAF, 8'h9A,
    8'hBF, 8'hAB, 8'hD6, 8'hCD, 8'h02, 8'hF2, 8'h7C, 8'hAA,
    8'hB2, 8'h92, 8'hFF, 8'h57, 8'h2F, 8'h86, 8'hA6, 8'h7D,
    8'h35, 8'h17, 8'h34, 8'hD5, 8'h0E, 8'h65, 8'h09, 8'h05,
    8'h28, 8'hCA, 8'h48, 8'h31, 8'h8E, 8'h2D, 8'hDF, 8'h52,
    8'hF6, 8'h1F, 8'hA4, 8'h50, 8'h76, 8'h40, 8'h18, 8'h04,
    8'h8A, 8'h16, 8'h2B, 8'hAE, 8'h43, 8'h3F, 8'hD0, 8'hCB,
    8'h6C, 8'h55, 8'h54, 8'h96, 8'h99, 8'h30, 8'h67, 8'h5E,
    8'h2C, 8'hAC, 8'hE0, 8'h7A, 8'hE8, 8'h58, 8'h90, 8'hBE,
    8'hA5, 8'h6F, 8'hB0, 8'h70, 8'hEC, 8'h61, 8'h5C, 8'h06,
    8'h3B, 8'h77, 8'hC1, 8'h07, 8'hEA, 8'hA9, 8'hF8, 8'h11,
    8'hBD, 8'hF3, 8'h00, 8'hED, 8'h83, 8'hEF, 8'h3D, 8'hA3,
    8'h51, 8'h9E, 8'h38, 8'hF7, 8'h0B, 8'hB9, 8'hD2, 8'hD1
  };

endpackage
`default_nettype wire

### design/sbe_pack.sv
// Substitutes one byte and repacks it with the carried bits into six-bit groups.
// Combinational; depends on sbe_pkg.
`default_nettype none
module sbe_pack (
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  input  wire logic [5:0]      carry_bits,
  input  wire sbe_pkg::phase_t phase,
  output sbe_pkg::pair_t       pair,
  output logic [5:0]           carry_nxt,
  output sbe_pkg::phase_t      phase_nxt
);

  logic [7:0] sub;

  assign sub = sbe_pkg::SUBST_TAB[data_byte] ^ sbe_pkg::KEY_XOR;

  always_comb begin
    pair      = '0;
    carry_nxt = '0;
    phase_nxt = sbe_pkg::PH_NONE;
    unique case (phase)
      sbe_pkg::PH_TWO: begin
        pair.grp0 = carry_bits | {2'b00, sub[7:4]};
        carry_nxt = {sub[3:0], 2'b00};
        phase_nxt = sbe_pkg::PH_FOUR;
      end
      sbe_pkg::PH_FOUR: begin
        // Three bytes fill exactly four groups, so nothing is carried.
        pair.grp0 = carry_bits | {4'b0000, sub[7:6]};
        pair.grp1 = sub[5:0];
        pair.two  = 1'b1;
        pair.eom  = last_byte;
      end
      default: begin
        // The unused phase code behaves as no leftover bits.
        pair.grp0 = carry_bits | sub[7:2];
        carry_nxt = {sub[1:0], 4'b0000};
        phase_nxt = sbe_pkg::PH_TWO;
      end
    endcase
    // The last byte flushes the leftover bits as one more character.
    if (last_byte && !pair.two) begin
      pair.grp1 = carry_nxt;
      pair.two  = 1'b1;
      pair.eom  = 1'b1;
      carry_nxt = '0;
      phase_nxt = sbe_pkg::PH_NONE;
    end
  end

endmodule
`default_nettype wire

### design/sbe_out_buf.sv
// Result register holding the one or two characters of a byte and sending them in turn.
// Depends on sbe_pkg.
`default_nettype none
module sbe_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire sbe_pkg::pair_t pair_in,
  output logic                free,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  sbe_pkg::pair_t pair_r;
  logic           vld_r;
  logic           sec_r;
  logic           last_beat;
  logic [5:0]     grp;

  assign last_beat = !pair_r.two || sec_r;
  assign free      = !vld_r || (out_tready && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sec_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
      sec_r <= 1'b0;
    end else if (vld_r && out_tready) begin
      if (last_beat) begin
        vld_r <= 1'b0;
      end else begin
        sec_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair_r <= pair_in;
    end
  end

  assign grp        = sec_r ? pair_r.grp1 : pair_r.grp0;
  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, {1'b0, grp} + sbe_pkg::CHAR_BIAS};
  assign out_tlast  = last_beat;
  assign out_tuser  = sec_r && pair_r.eom;

endmodule
`default_nettype wire

### design/six_bit_substitution_encoder_unit.sv
// Six-bit substitution encoder top level; uses sbe_pkg, sbe_pack and sbe_out_buf.
// Path: a byte moves from the input register into the result register, which then puts its
// first character on the output; while the result register is busy, the byte waits.
// Throughput: one byte per cycle while the receiver takes every character and each byte
// gives one; a byte that gives two holds the result register until both have gone out.
// Reset: synchronous, active low; clears the valid flags, the carried bits and the phase.
`default_nettype none
module six_bit_substitution_encoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] data_byte
  input  wire logic       in_tlast,     // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [6:0] out_char, [7] zero
  output logic            out_tlast,    // last_of_run
  output logic            out_tuser     // end_of_message
);

  // Input register. It takes a new byte whenever it is empty or its byte moves on
  // into the result register in the same cycle.
  logic [7:0]      byte_r;
  logic            last_r;
  logic            in_vld_r;

  // Encoder state: leftover bits, already placed at their position in the next group.
  logic [5:0]      carry_r;
  sbe_pkg::phase_t phase_r;

  logic [5:0]      carry_nxt;
  sbe_pkg::phase_t phase_nxt;
  sbe_pkg::pair_t  pair;
  logic            buf_free;
  logic            advance;

  assign advance   = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // The state moves on exactly when a byte is handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      phase_r <= sbe_pkg::PH_NONE;
    end else if (advance) begin
      carry_r <= carry_nxt;
      phase_r <= phase_nxt;
    end
  end

  sbe_pack u_pack (
    .data_byte  (byte_r),
    .last_byte  (last_r),
    .carry_bits (carry_r),
    .phase      (phase_r),
    .pair       (pair),
    .carry_nxt  (carry_nxt),
    .phase_nxt  (phase_nxt)
  );

  sbe_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .pair_in    (pair),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The end of a message is always the last character of its byte.
  a_eom_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of message on a character that is not last of its byte");

  // After the last byte of a message the encoder returns to its reset state.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> (phase_r == sbe_pkg::PH_NONE) && (carry_r == 6'd0))
    else $error("state not cleared after the last byte");

  // The first of two characters is always followed by the second.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second character of a byte went missing");

endmodule
`default_nettype wire

### bench/six_bit_substitution_encoder_unit_tb.sv
// Self-checking bench for six_bit_substitution_encoder_unit: byte messages in, characters out.
// A bit-exact predictor of the substitution and six-bit repacking checks every output transfer.
// Depends on sbe_pkg and the encoder top level.
`timescale 1ns / 100ps
`default_nettype none
module six_bit_substitution_encoder_unit_tb;

  localparam int QUIET_LIMIT = 2000;   // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 300;    // length of the receiver's long hold-off
  localparam int ITEM_TARGET = 750;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       run_end;
    logic       msg_end;
  } char_exp_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  byte_item_t pend_q[$];
  char_exp_t  char_q[$];

  // Predictor state: carried bits and how many of them are held.
  sbe_pkg::phase_t enc_phase = sbe_pkg::PH_NONE;
  logic [5:0]      enc_carry = '0;

  bit in_took, out_took;
  bit tx_burst, rx_burst;
  int tx_gap, rx_gap, hold_left;
  int hold_requests, hold_served;
  int quiet_cycles;
  int err_count;
  int items_sent;

  six_bit_substitution_encoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic void push_char(logic [5:0] grp, logic run_end, logic msg_end);
    char_exp_t e;
    e.ch      = {1'b0, grp} + sbe_pkg::CHAR_BIAS;
    e.run_end = run_end;
    e.msg_end = msg_end;
    char_q.insert(char_q.size(), e);
  endfunction

  // Substitute, whiten, then cut the bit stream MSB first into six-bit groups.
  function automatic void predict_chars(logic [7:0] data, logic last);
    logic [7:0] sub;
    logic [5:0] grp;
    sub = sbe_pkg::SUBST_TAB[data] ^ sbe_pkg::KEY_XOR;
    unique case (enc_phase)
      sbe_pkg::PH_TWO: begin
        grp       = enc_carry | {2'b00, sub[7:4]};
        enc_carry = {sub[3:0], 2'b00};
        enc_phase = sbe_pkg::PH_FOUR;
      end
      sbe_pkg::PH_FOUR: begin
        // 24 bits complete: two characters, nothing left to flush.
        push_char(enc_carry | {4'b0000, sub[7:6]}, 1'b0, 1'b0);
        push_char(sub[5:0], 1'b1, last);
        enc_carry = '0;
        enc_phase = sbe_pkg::PH_NONE;
        return;
      end
      default: begin
        // The unused phase code behaves like no leftover bits, carry kept.
        grp       = enc_carry | sub[7:2];
        enc_carry = {sub[1:0], 4'b0000};
        enc_phase = sbe_pkg::PH_TWO;
      end
    endcase
    if (last) begin
      push_char(grp, 1'b0, 1'b0);
      push_char(enc_carry, 1'b1, 1'b1);
      enc_carry = '0;
      enc_phase = sbe_pkg::PH_NONE;
    end else begin
      push_char(grp, 1'b1, 1'b0);
    end
  endfunction

  task automatic check_char();
    char_exp_t e;
    if (char_q.size() == 0) begin
      report_mismatch($sformatf("character %02h with nothing expected", out_tdata));
    end else begin
      e = char_q.pop_front();
      if (out_tdata !== {1'b0, e.ch}) begin
        report_mismatch($sformatf("out_char got %02h want %02h", out_tdata, e.ch));
      end
      if (out_tlast !== e.run_end) begin
        report_mismatch($sformatf("last_of_run got %b want %b", out_tlast, e.run_end));
      end
      if (out_tuser !== e.msg_end) begin
        report_mismatch($sformatf("end_of_message got %b want %b", out_tuser, e.msg_end));
      end
    end
  endtask

  // Monitor: sample both channels at the rising edge, predict on input, check on output.
  always @(posedge clk) begin
    in_took  = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        predict_chars(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        out_took = 1'b1;
        check_char();
      end
    end
    if (in_took || out_took) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Driver: one byte at a time from the pending queue, with a drawn gap after each transfer.
  always @(negedge clk) begin
    logic       nv;
    byte_item_t cur;
    nv = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_took) begin
        nv     = 1'b0;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_tdata <= cur.data;
          in_tlast <= cur.last;
          nv = 1'b1;
        end
      end
    end
    in_tvalid <= nv;
  end

  // Receiver: drawn stall after each character, plus long hold-offs on request.
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (rst_n) begin
      if (out_took) rx_gap = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        nr = 1'b1;
      end
    end
    out_tready <= nr;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("six_bit_substitution_encoder_unit_tb: done, errors");
    $finish;
  end

  task automatic push_byte(logic [7:0] data, logic last);
    byte_item_t it;
    it.data = data;
    it.last = last;
    pend_q.insert(pend_q.size(), it);
    items_sent++;
  endtask

  task automatic push_message(int len);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (!(pend_q.size() == 0 && !in_tvalid && char_q.size() == 0)) @(posedge clk);
  endtask

  initial begin
    int len;
    int chunk;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: flush from each phase, extreme bytes, full three-byte cycles.
    push_byte(8'h00, 1'b1);                          // last byte with two bits left
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);  // last byte with four bits left
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);                          // last byte fills the group, no flush
    push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hF2, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h0F, 1'b0); push_byte(8'hF0, 1'b0); push_byte(8'h3C, 1'b1);
    wait_drained();

    // Random messages, mostly short, now and then a long one.
    chunk = 0;
    while (items_sent < ITEM_TARGET) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (chunk == 3) begin
        // Keep bytes flowing into a receiver that holds off, so the input backs up.
        tx_burst = 1'b1;
        hold_requests++;
      end
      for (int n = 0; n < 60; n += len) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
        push_message(len);
      end
      while (pend_q.size() > 8) @(posedge clk);
      if (chunk % 4 == 1) begin
        // Sender stops until every character has arrived.
        wait_drained();
        repeat (20) @(posedge clk);
      end
      chunk++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (char_q.size() != 0) report_mismatch("characters still expected at the end");
    if (err_count == 0) begin
      $display("six_bit_substitution_encoder_unit_tb: done, clean");
    end else begin
      $display("six_bit_substitution_encoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
